/* hdl/dcpsp_pkg.sv */
// ----------------------------------------------------------------------------
// dcpsp_pkg
// shared types and constants of the polygon stream parser
// ----------------------------------------------------------------------------
package dcpsp_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PRESENT  = 2'd2;

    localparam logic [7:0] LINEARRING    = 8'd1;
    localparam logic [7:0] OUTERBOUNDARY = 8'd2;
    localparam logic [7:0] INNERBOUNDARY = 8'd3;
    localparam logic [7:0] MULTIGEOMETRY = 8'd4;

    localparam logic signed [15:0] LAT_MIN = -16'sd10800;
    localparam logic signed [15:0] LAT_MAX =  16'sd10800;
    localparam logic signed [15:0] LON_MIN = -16'sd21600;
    localparam logic signed [15:0] LON_MAX =  16'sd21600;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_COORD  = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        PH_START, PH1_ID, PH1_NABS, PH1_FLAG, PH1_COLOR,
        PH2_FLAG, PH2_ID, PH2_COLOR, PH2_NABS, PH2_MSIZE,
        PHM_FLAG, PHM_ID, PHM_NABS,
        PHN_LAT, PHN_LON, PHN_CNT, PHD_LAT, PHD_LON
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  geometry_type;
        logic [31:0] placemark_id;
        logic        new_placemark;
        logic [7:0]  color_index;
        logic        color_valid;
        logic        in_multi;
        logic [15:0] latitude;
        logic [15:0] longitude;
        logic        absolute_node;
        logic        error_seen;
    } t_result;

    localparam int unsigned RES_W = $bits(t_result);
    localparam int unsigned TDATA_W = 88;

    function automatic logic in_range(logic [15:0] lat, logic [15:0] lon);
        return ($signed(lat) >= LAT_MIN) && ($signed(lat) <= LAT_MAX) &&
               ($signed(lon) >= LON_MIN) && ($signed(lon) <= LON_MAX);
    endfunction

endpackage

/* hdl/dcpsp_parser.sv */
// ----------------------------------------------------------------------------
// dcpsp_parser
// record field state machine; one byte in, at most one result out
// ----------------------------------------------------------------------------
module dcpsp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dcpsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcpsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_byte_vld,
    input  logic [7:0]                    i_byte,
    output logic                          o_res_vld,
    output dcpsp_pkg::t_result            o_res
);
    import dcpsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_recs, n_recs;
    logic [7:0]  r_mleft, n_mleft;
    logic [31:0] r_aleft, n_aleft;
    logic [14:0] r_dleft, n_dleft;
    logic [15:0] r_alat, n_alat, r_alon, n_alon;
    logic [31:0] r_prev, n_prev, r_cur, n_cur;
    logic [7:0]  r_flag, n_flag, r_col, n_col;
    logic        r_multi, n_multi, r_err, n_err, r_fin, n_fin;
    logic [1:0]  r_ver;
    logic        r_colp;

    logic [31:0] sh;
    logic [2:0]  cnt_inc;
    logic        full2, full4, np;
    logic [15:0] dlat, dlon, clat, clon;
    t_phase      ph;
    logic        cap;
    t_result     res;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_shift = r_shift; n_recs = r_recs;
        n_mleft = r_mleft; n_aleft = r_aleft; n_dleft = r_dleft;
        n_alat = r_alat; n_alon = r_alon; n_prev = r_prev; n_cur = r_cur;
        n_flag = r_flag; n_col = r_col; n_multi = r_multi; n_err = r_err; n_fin = r_fin;
        res = '0;
        cap = 1'b0;
        ph = r_phase;
        sh = (r_cnt == 3'd0) ? {24'd0, i_byte} : {r_shift[23:0], i_byte};
        cnt_inc = r_cnt + 3'd1;
        full2 = (cnt_inc >= 3'd2);
        full4 = (cnt_inc >= 3'd4);
        np = (r_cur != r_prev);
        dlat = r_alat + {{8{r_shift[7]}}, r_shift[7:0]};
        dlon = r_alon + {{8{i_byte[7]}}, i_byte};
        clat = '0;
        clon = '0;
        if (i_byte_vld && !r_fin) begin
            if (r_phase == PH_START) begin
                if (r_recs == '0 || r_err || (r_ver != 2'd1 && r_ver != 2'd2)) begin
                    res.kind = KIND_DONE;
                    res.color_index = r_col;
                    res.error_seen = r_err;
                    cap = 1'b1;
                    n_fin = 1'b1;
                end else begin
                    ph = (r_ver == 2'd1) ? PH1_ID : PH2_FLAG;
                    sh = {24'd0, i_byte};
                    cnt_inc = 3'd1;
                    full2 = 1'b0;
                    full4 = 1'b0;
                end
            end
            if (!n_fin) begin
                // field assembly shared by the multi-byte phases
                n_shift = sh;
                n_cnt = (full4 || ((ph == PHN_LAT || ph == PHN_LON || ph == PHN_CNT) && full2))
                      ? 3'd0 : cnt_inc;
                case (ph)
                    PH1_ID: if (full4) begin n_cur = sh; n_phase = PH1_NABS; end
                            else n_phase = PH1_ID;
                    PH1_NABS: if (full4) begin n_aleft = sh; n_phase = PH1_FLAG; end
                    PH1_FLAG, PH1_COLOR, PH2_NABS, PH2_MSIZE, PHM_NABS: begin
                        n_cnt = r_cnt;
                        n_shift = r_shift;
                        if (ph == PH2_NABS || ph == PHM_NABS) begin
                            n_cnt = full4 ? 3'd0 : cnt_inc;
                            n_shift = sh;
                        end
                        if (ph == PH1_FLAG) n_flag = i_byte;
                        if (ph == PH1_COLOR) n_col = i_byte;
                        if (ph == PH1_FLAG && i_byte == OUTERBOUNDARY && r_colp) begin
                            n_phase = PH1_COLOR;
                        end else if ((ph == PH2_NABS || ph == PHM_NABS) && !full4) begin
                            n_phase = ph;
                        end else begin
                            cap = 1'b1;
                            res.kind = KIND_HEADER;
                            res.geometry_type = (ph == PH1_FLAG) ? i_byte : r_flag;
                            res.placemark_id = r_cur;
                            res.color_index = (ph == PH1_COLOR) ? i_byte : r_col;
                            res.error_seen = r_err;
                            if (ph == PHM_NABS) begin
                                res.in_multi = 1'b1;
                            end else begin
                                res.new_placemark = np;
                                n_prev = r_cur;
                                res.color_valid = (ph == PH1_COLOR) ||
                                    ((ph == PH2_NABS || ph == PH2_MSIZE) && r_colp && np);
                            end
                            if (ph == PH2_MSIZE) begin
                                n_mleft = i_byte;
                                if (i_byte == 8'd0) begin
                                    n_multi = 1'b0;
                                    if (r_recs != '0) n_recs = r_recs - 32'd1;
                                    n_phase = PH_START;
                                    n_cnt = '0;
                                end else begin
                                    n_multi = 1'b1;
                                    n_phase = PHM_FLAG;
                                end
                            end else begin
                                // begin geometry
                                if (ph == PH2_NABS || ph == PHM_NABS) n_aleft = sh;
                                n_cnt = '0;
                                if (((ph == PH1_FLAG) ? i_byte : r_flag) <= INNERBOUNDARY &&
                                    ((ph == PH2_NABS || ph == PHM_NABS) ? sh : r_aleft) != '0)
                                    n_phase = PHN_LAT;
                                else if (r_multi && r_mleft != 8'd1) begin
                                    n_mleft = r_mleft - 8'd1;
                                    n_phase = PHM_FLAG;
                                end else begin
                                    if (r_multi) n_mleft = r_mleft - 8'd1;
                                    n_multi = 1'b0;
                                    if (r_recs != '0) n_recs = r_recs - 32'd1;
                                    n_phase = PH_START;
                                end
                            end
                        end
                    end
                    PH2_FLAG: begin
                        n_flag = i_byte; n_phase = PH2_ID;
                        n_cnt = '0; n_shift = r_shift;
                    end
                    PH2_ID: if (full4) begin
                        n_cur = sh;
                        if (sh != r_prev && r_colp) n_phase = PH2_COLOR;
                        else n_phase = (r_flag == MULTIGEOMETRY) ? PH2_MSIZE : PH2_NABS;
                    end
                    PH2_COLOR: begin
                        n_col = i_byte; n_cnt = r_cnt; n_shift = r_shift;
                        n_phase = (r_flag == MULTIGEOMETRY) ? PH2_MSIZE : PH2_NABS;
                    end
                    PHM_FLAG: begin
                        n_flag = i_byte; n_cnt = '0; n_shift = r_shift;
                        n_phase = PHM_ID;
                    end
                    PHM_ID: if (full4) n_phase = PHM_NABS;
                    PHN_LAT: if (full2) begin n_alat = sh[15:0]; n_phase = PHN_LON; end
                    PHN_LON: if (full2) begin
                        n_alon = sh[15:0];
                        clat = r_alat; clon = sh[15:0];
                        cap = 1'b1;
                        res.absolute_node = 1'b1;
                        n_phase = PHN_CNT;
                    end
                    PHN_CNT: if (full2) begin
                        if (!sh[15] && sh[15:0] != 16'd0) begin
                            n_dleft = sh[14:0];
                            n_phase = PHD_LAT;
                        end else begin
                            n_aleft = r_aleft - 32'd1;
                            n_phase = PHN_LAT;
                        end
                    end
                    PHD_LAT: begin
                        n_shift = {24'd0, i_byte}; n_cnt = r_cnt;
                        n_phase = PHD_LON;
                    end
                    PHD_LON: begin
                        n_shift = r_shift; n_cnt = r_cnt;
                        clat = dlat; clon = dlon;
                        cap = 1'b1;
                        n_dleft = r_dleft - 15'd1;
                        if (r_dleft != 15'd1) n_phase = PHD_LAT;
                        else begin
                            n_aleft = r_aleft - 32'd1;
                            n_phase = PHN_LAT;
                        end
                    end
                    default: begin
                        n_phase = PH_START; n_cnt = '0;
                    end
                endcase
                // node finished: leave geometry when the anchor count runs out
                if (n_phase == PHN_LAT && (ph == PHN_CNT || ph == PHD_LON) &&
                    n_aleft == '0) begin
                    n_cnt = '0;
                    if (r_multi && r_mleft != 8'd1) begin
                        n_mleft = r_mleft - 8'd1;
                        n_phase = PHM_FLAG;
                    end else begin
                        if (r_multi) n_mleft = r_mleft - 8'd1;
                        n_multi = 1'b0;
                        if (r_recs != '0) n_recs = r_recs - 32'd1;
                        n_phase = PH_START;
                    end
                end
                if (ph == PHN_LON || ph == PHD_LON) begin
                    if (!(ph == PHN_LON && !full2)) begin
                        res.kind = KIND_COORD;
                        res.geometry_type = r_flag;
                        res.placemark_id = r_cur;
                        res.color_index = r_col;
                        res.in_multi = r_multi;
                        res.latitude = clat;
                        res.longitude = clon;
                        if (!in_range(clat, clon)) n_err = 1'b1;
                        res.error_seen = n_err;
                    end
                end
            end
        end
        if (i_cfg_we && i_cfg_idx == REG_RECORD_COUNT) n_recs = i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_cnt <= '0; r_shift <= '0; r_recs <= '0;
            r_mleft <= '0; r_aleft <= '0; r_dleft <= '0; r_alat <= '0; r_alon <= '0;
            r_prev <= '0; r_cur <= '0; r_flag <= '0; r_col <= '0;
            r_multi <= 1'b0; r_err <= 1'b0; r_fin <= 1'b0;
            r_ver <= 2'd2; r_colp <= 1'b0;
            o_res_vld <= 1'b0;
        end else begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_shift <= n_shift; r_recs <= n_recs;
            r_mleft <= n_mleft; r_aleft <= n_aleft; r_dleft <= n_dleft;
            r_alat <= n_alat; r_alon <= n_alon; r_prev <= n_prev; r_cur <= n_cur;
            r_flag <= n_flag; r_col <= n_col; r_multi <= n_multi; r_err <= n_err;
            r_fin <= n_fin;
            if (i_cfg_we && i_cfg_idx == REG_FORMAT_VERSION) r_ver <= i_cfg_data[1:0];
            if (i_cfg_we && i_cfg_idx == REG_COLOR_PRESENT) r_colp <= i_cfg_data[0];
            o_res_vld <= cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap) o_res <= res;
    end

endmodule

/* hdl/dcpsp_skid.sv */
// ----------------------------------------------------------------------------
// dcpsp_skid
// output register with one skid entry between parser and stream master
// ----------------------------------------------------------------------------
module dcpsp_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  dcpsp_pkg::t_result i_res,
    output logic               o_space,
    output logic               o_vld,
    input  logic               i_rdy,
    output dcpsp_pkg::t_result o_res
);
    import dcpsp_pkg::*;

    logic    r_vld0, r_vld1;
    t_result r_d0, r_d1;

    assign o_vld   = r_vld0;
    assign o_res   = r_d0;
    // room for the result of a request taken now, counting the one in flight
    assign o_space = !r_vld1 ? (!(r_vld0 && i_vld) || i_rdy) : (!i_vld && i_rdy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (!r_vld0 || i_rdy) begin
                r_vld0 <= r_vld1 || i_vld;
                r_vld1 <= 1'b0;
            end else if (i_vld) begin
                r_vld1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_vld0 || i_rdy) begin
            r_d0 <= r_vld1 ? r_d1 : i_res;
        end else if (i_vld) begin
            r_d1 <= i_res;
        end
    end

endmodule

/* hdl/delta_coded_polygon_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// delta_coded_polygon_stream_parser_core
// byte stream parser for delta coded polygon records
// ----------------------------------------------------------------------------
// One body byte is taken per cycle whenever the output side has room; each
// byte passes through the field state machine and yields
// at most one result, which is registered and buffered in a two-entry skid
// stage, so the sustained rate is one byte per clock under no backpressure.
module delta_coded_polygon_stream_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [dcpsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcpsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // geometry_type, placemark_id, new_placemark, color_index, color_valid, in_multi,
    // latitude, longitude, absolute_node, error_seen, zero fill
    output logic [dcpsp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // kind
);
    import dcpsp_pkg::*;

    logic    res_vld, space;
    t_result res, out;

    assign s_axis_tready = space;

    dcpsp_parser u_parser (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_byte_vld(s_axis_tvalid && space), .i_byte(s_axis_tdata),
        .o_res_vld(res_vld), .o_res(res)
    );

    dcpsp_skid u_skid (
        .i_clk, .i_rst_n, .i_vld(res_vld), .i_res(res), .o_space(space),
        .o_vld(m_axis_tvalid), .i_rdy(m_axis_tready), .o_res(out)
    );

    assign m_axis_tuser = out.kind;
    assign m_axis_tdata = {3'd0, out.error_seen, out.absolute_node, out.longitude,
                           out.latitude, out.in_multi, out.color_valid, out.color_index,
                           out.new_placemark, out.placemark_id, out.geometry_type};

endmodule

/* hdl/dcpsp_checker.sv */
// ----------------------------------------------------------------------------
// dcpsp_checker
// port level checks of the polygon stream parser
// ----------------------------------------------------------------------------
module dcpsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [1:0] m_axis_tuser,
    input logic [87:0] m_axis_tdata
);
    import dcpsp_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad kind");

    // done carries only the colour index and the error flag
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DONE |->
            m_axis_tdata[40:0] == '0 && m_axis_tdata[83:49] == '0)
        else $error("done item carries payload");

    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind delta_coded_polygon_stream_parser_core dcpsp_checker u_checker (
    .i_clk, .i_rst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tuser, .m_axis_tdata
);

/* tb/sv/delta_coded_polygon_stream_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// delta_coded_polygon_stream_parser_core_tb
// Feeds polygon record bodies in both layouts through the parser byte by byte,
// predicts every header, coordinate and done result in step with each accepted
// byte, and checks the result stream field by field under random idling and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module delta_coded_polygon_stream_parser_core_tb;
    import dcpsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    delta_coded_polygon_stream_parser_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state mirrored in the testbench
    logic [1:0]  mv_version;
    logic        mv_color_en;
    t_phase      mv_phase;
    int          mv_nbytes;
    logic [31:0] mv_shift, mv_recs_left, mv_anchors, mv_prev_pm, mv_cur_pm;
    logic [7:0]  mv_members, mv_flag, mv_color;
    int          mv_deltas;
    logic [15:0] mv_alat, mv_alon;
    logic        mv_in_multi, mv_err, mv_finished;

    logic [7:0] byte_q[$];
    t_result    result_q[$];
    int         n_err = 0;
    int         n_results = 0;

    function automatic bit gather(input logic [7:0] b, input int n);
        mv_shift = (mv_nbytes == 0) ? {24'd0, b} : {mv_shift[23:0], b};
        mv_nbytes++;
        if (mv_nbytes >= n) begin
            mv_nbytes = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_result(t_kind k, logic [7:0] typ, logic [31:0] pid,
                                        logic np, logic cv, logic im,
                                        logic [15:0] lat, logic [15:0] lon, logic ab);
        t_result r;
        r.kind = k;
        r.geometry_type = typ;
        r.placemark_id = pid;
        r.new_placemark = np;
        r.color_index = mv_color;
        r.color_valid = cv;
        r.in_multi = im;
        r.latitude = lat;
        r.longitude = lon;
        r.absolute_node = ab;
        r.error_seen = mv_err;
        result_q.push_back(r);
    endfunction

    function automatic void top_header(logic cv);
        logic np;
        np = (mv_cur_pm != mv_prev_pm);
        mv_prev_pm = mv_cur_pm;
        push_result(KIND_HEADER, mv_flag, mv_cur_pm, np, cv, 1'b0, '0, '0, 1'b0);
    endfunction

    function automatic void node_result(logic [15:0] lat, logic [15:0] lon, logic ab);
        if ($signed(lat) < LAT_MIN || $signed(lat) > LAT_MAX ||
            $signed(lon) < LON_MIN || $signed(lon) > LON_MAX)
            mv_err = 1'b1;
        push_result(KIND_COORD, mv_flag, mv_cur_pm, 1'b0, 1'b0, mv_in_multi, lat, lon, ab);
    endfunction

    function automatic void record_end();
        mv_in_multi = 1'b0;
        if (mv_recs_left != 0) mv_recs_left--;
        mv_phase = PH_START;
        mv_nbytes = 0;
    endfunction

    function automatic void geometry_end();
        if (mv_in_multi) begin
            mv_members = mv_members - 8'd1;
            if (mv_members != 0) begin
                mv_phase = PHM_FLAG;
                return;
            end
        end
        record_end();
    endfunction

    function automatic void geometry_begin();
        mv_nbytes = 0;
        if (mv_flag <= INNERBOUNDARY && mv_anchors != 0) mv_phase = PHN_LAT;
        else geometry_end();
    endfunction

    function automatic void node_end();
        mv_anchors--;
        if (mv_anchors != 0) mv_phase = PHN_LAT;
        else geometry_end();
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [15:0] dlat, dlon;
        logic signed [15:0] cnt;
        logic cv;
        if (mv_finished) return;
        if (mv_phase == PH_START) begin
            if (mv_recs_left == 0 || mv_err || (mv_version != 2'd1 && mv_version != 2'd2)) begin
                push_result(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
                mv_finished = 1'b1;
                return;
            end
            mv_nbytes = 0;
            mv_phase = (mv_version == 2'd1) ? PH1_ID : PH2_FLAG;
        end
        cv = mv_color_en && (mv_cur_pm != mv_prev_pm);
        case (mv_phase)
            PH1_ID: if (gather(b, 4)) begin
                mv_cur_pm = mv_shift;
                mv_phase = PH1_NABS;
            end
            PH1_NABS: if (gather(b, 4)) begin
                mv_anchors = mv_shift;
                mv_phase = PH1_FLAG;
            end
            PH1_FLAG: begin
                mv_flag = b;
                if (b == OUTERBOUNDARY && mv_color_en) mv_phase = PH1_COLOR;
                else begin
                    top_header(1'b0);
                    geometry_begin();
                end
            end
            PH1_COLOR: begin
                mv_color = b;
                top_header(1'b1);
                geometry_begin();
            end
            PH2_FLAG: begin
                mv_flag = b;
                mv_phase = PH2_ID;
            end
            PH2_ID: if (gather(b, 4)) begin
                mv_cur_pm = mv_shift;
                if (mv_cur_pm != mv_prev_pm && mv_color_en) mv_phase = PH2_COLOR;
                else mv_phase = (mv_flag == MULTIGEOMETRY) ? PH2_MSIZE : PH2_NABS;
            end
            PH2_COLOR: begin
                mv_color = b;
                mv_phase = (mv_flag == MULTIGEOMETRY) ? PH2_MSIZE : PH2_NABS;
            end
            PH2_NABS: if (gather(b, 4)) begin
                mv_anchors = mv_shift;
                top_header(cv);
                geometry_begin();
            end
            PH2_MSIZE: begin
                top_header(cv);
                mv_members = b;
                if (b == 0) record_end();
                else begin
                    mv_in_multi = 1'b1;
                    mv_phase = PHM_FLAG;
                end
            end
            PHM_FLAG: begin
                mv_flag = b;
                mv_nbytes = 0;
                mv_phase = PHM_ID;
            end
            PHM_ID: if (gather(b, 4)) mv_phase = PHM_NABS;
            PHM_NABS: if (gather(b, 4)) begin
                mv_anchors = mv_shift;
                push_result(KIND_HEADER, mv_flag, mv_cur_pm, 1'b0, 1'b0, 1'b1, '0, '0, 1'b0);
                geometry_begin();
            end
            PHN_LAT: if (gather(b, 2)) begin
                mv_alat = mv_shift[15:0];
                mv_phase = PHN_LON;
            end
            PHN_LON: if (gather(b, 2)) begin
                mv_alon = mv_shift[15:0];
                node_result(mv_alat, mv_alon, 1'b1);
                mv_phase = PHN_CNT;
            end
            PHN_CNT: if (gather(b, 2)) begin
                cnt = mv_shift[15:0];
                if (cnt > 0) begin
                    mv_deltas = int'(cnt);
                    mv_phase = PHD_LAT;
                end else begin
                    node_end();
                end
            end
            PHD_LAT: begin
                mv_shift = {24'd0, b};
                mv_phase = PHD_LON;
            end
            PHD_LON: begin
                dlat = {{8{mv_shift[7]}}, mv_shift[7:0]};
                dlon = {{8{b[7]}}, b};
                node_result(mv_alat + dlat, mv_alon + dlon, 1'b0);
                mv_deltas--;
                if (mv_deltas == 0) node_end();
                else mv_phase = PHD_LAT;
            end
            default: begin
                mv_phase = PH_START;
                mv_nbytes = 0;
            end
        endcase
    endfunction

    // byte source
    int src_gap = 0;
    bit src_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
            if ($urandom_range(0, 39) == 0) src_burst <= !src_burst;
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                s_axis_tdata <= byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                src_gap <= src_burst ? 0 : $urandom_range(0, 10);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink and checker
    int sink_stall = 0;
    int sink_next;
    bit sink_burst = 1'b0;
    t_result got, want;

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall <= 0;
        end else begin
            if ($urandom_range(0, 39) == 0) sink_burst <= !sink_burst;
            sink_next = sink_stall;
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.geometry_type = m_axis_tdata[7:0];
                got.placemark_id = m_axis_tdata[39:8];
                got.new_placemark = m_axis_tdata[40];
                got.color_index = m_axis_tdata[48:41];
                got.color_valid = m_axis_tdata[49];
                got.in_multi = m_axis_tdata[50];
                got.latitude = m_axis_tdata[66:51];
                got.longitude = m_axis_tdata[82:67];
                got.absolute_node = m_axis_tdata[83];
                got.error_seen = m_axis_tdata[84];
                if (result_q.size() == 0) begin
                    $error("result with none expected, kind %0d", got.kind);
                    n_err++;
                end else begin
                    want = result_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("geometry_type", 32'(want.geometry_type),
                                32'(got.geometry_type));
                    check_field("placemark_id", want.placemark_id, got.placemark_id);
                    check_field("new_placemark", 32'(want.new_placemark),
                                32'(got.new_placemark));
                    check_field("color_index", 32'(want.color_index), 32'(got.color_index));
                    check_field("color_valid", 32'(want.color_valid), 32'(got.color_valid));
                    check_field("in_multi", 32'(want.in_multi), 32'(got.in_multi));
                    check_field("latitude", 32'(want.latitude), 32'(got.latitude));
                    check_field("longitude", 32'(want.longitude), 32'(got.longitude));
                    check_field("absolute_node", 32'(want.absolute_node),
                                32'(got.absolute_node));
                    check_field("error_seen", 32'(want.error_seen), 32'(got.error_seen));
                end
                n_results++;
                sink_next = sink_burst ? 0 : $urandom_range(0, 10);
                // long hold-off so the parser backs up into its input
                if (n_results == 60) sink_next = 400;
            end
            if (sink_next > 0) begin
                m_axis_tready <= 1'b0;
                sink_stall <= sink_next - 1;
            end else begin
                m_axis_tready <= 1'b1;
                sink_stall <= 0;
            end
        end
    end

    // record generation
    logic [1:0]  gen_version;
    logic        gen_color;
    logic [31:0] gen_prev = '0;
    int          gen_total = 0;

    task automatic put8(logic [7:0] b);
        byte_q.push_back(b);
        gen_total++;
    endtask

    task automatic put16(logic [15:0] v);
        put8(v[15:8]);
        put8(v[7:0]);
    endtask

    task automatic put32(logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic put_nodes(int n, bit bad);
        logic [15:0] lat, lon, cnt;
        for (int i = 0; i < n; i++) begin
            lat = 16'($urandom_range(0, 2 * 10672) - 10672);
            lon = 16'($urandom_range(0, 2 * 21472) - 21472);
            if (bad) lat = 16'(($urandom_range(0, 1) ? 16'd10801 : -16'sd10801) +
                               ($urandom_range(0, 1) ? $urandom_range(0, 20000) : 0));
            cnt = ($urandom_range(0, 7) == 0) ? 16'(16'h8000 | $urandom) :
                                                16'($urandom_range(0, 3));
            put16(lat);
            put16(lon);
            put16(cnt);
            if (!cnt[15])
                for (int k = 0; k < cnt; k++) begin
                    put8(8'($urandom));
                    put8(8'($urandom));
                end
        end
    endtask

    function automatic logic [7:0] pick_flag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'(r % 4);
        if (r < 8) return MULTIGEOMETRY;
        return 8'($urandom_range(5, 255));
    endfunction

    function automatic logic [31:0] pick_count(logic [7:0] flag);
        return (flag <= INNERBOUNDARY) ? $urandom_range(0, 3) : $urandom;
    endfunction

    task automatic put_record(logic [7:0] flag, logic [31:0] id, bit bad);
        logic [31:0] cnt;
        logic [7:0]  mf, nm;
        cnt = bad ? 2 : pick_count(flag);
        if (gen_version == 2'd1) begin
            put32(id);
            put32(cnt);
            put8(flag);
            if (flag == OUTERBOUNDARY && gen_color) put8(8'($urandom));
            if (flag <= INNERBOUNDARY) put_nodes(cnt, bad);
        end else begin
            put8(flag);
            put32(id);
            if (id != gen_prev && gen_color) put8(8'($urandom));
            if (flag == MULTIGEOMETRY) begin
                nm = 8'($urandom_range(0, 3));
                put8(nm);
                for (int m = 0; m < nm; m++) begin
                    mf = pick_flag();
                    cnt = pick_count(mf);
                    put8(mf);
                    put32($urandom);
                    put32(cnt);
                    if (mf <= INNERBOUNDARY) put_nodes(cnt, 1'b0);
                end
            end else begin
                put32(cnt);
                if (flag <= INNERBOUNDARY) put_nodes(cnt, bad);
            end
        end
        gen_prev = id;
    endtask

    task automatic put_random_record();
        put_record(pick_flag(), $urandom_range(0, 1) ? gen_prev : $urandom, 1'b0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_FORMAT_VERSION: mv_version = val[1:0];
            REG_RECORD_COUNT:   mv_recs_left = val;
            REG_COLOR_PRESENT:  mv_color_en = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_layout(logic [1:0] ver, logic col);
        gen_version = ver;
        gen_color = col;
        cfg_write(REG_FORMAT_VERSION, 32'(ver));
        cfg_write(REG_COLOR_PRESENT, 32'(col));
    endtask

    initial begin
        int nrec, ending;
        mv_version = 2'd2; mv_color_en = 1'b0; mv_phase = PH_START; mv_nbytes = 0;
        mv_shift = '0; mv_recs_left = '0; mv_anchors = '0; mv_prev_pm = '0;
        mv_cur_pm = '0; mv_members = '0; mv_flag = '0; mv_color = '0; mv_deltas = 0;
        mv_alat = '0; mv_alon = '0; mv_in_multi = 1'b0; mv_err = 1'b0; mv_finished = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // layout 1 with colours: boundary nodes, negative delta count, unknown flag
        set_layout(2'd1, 1'b1);
        cfg_write(REG_RECORD_COUNT, 4);
        put32(32'hFFFF_FFFF); put32(2); put8(OUTERBOUNDARY); put8(8'hFF);
        put16(16'd10800); put16(-16'sd21600); put16(16'd0);
        put16(-16'sd10800); put16(16'd21600); put16(16'h8000);
        gen_prev = 32'hFFFF_FFFF;
        put_record(8'd7, 32'd0, 1'b0);
        put_record(MULTIGEOMETRY, 32'd0, 1'b0);
        put_record(LINEARRING, 32'h1234_5678, 1'b0);
        wait_idle();

        // layout 2, open-ended record count, empty and filled multigeometry
        set_layout(2'd2, 1'b1);
        cfg_write(REG_RECORD_COUNT, 32'hFFFF_FFFF);
        cfg_write(REG_SPARE, $urandom);
        put8(MULTIGEOMETRY); put32(32'hA5A5_0001); put8(8'hC3); put8(8'd0);
        put8(MULTIGEOMETRY); put32(32'h5A5A_0002); put8(8'h3C); put8(8'd2);
        put8(INNERBOUNDARY); put32($urandom); put32(1);
        put16(16'd100); put16(-16'sd100); put16(16'd2);
        put8(8'h7F); put8(8'h80); put8(8'h80); put8(8'h7F);
        put8(8'd9); put32($urandom); put32(32'hFFFF_FFFF);
        gen_prev = 32'h5A5A_0002;
        put_record(OUTERBOUNDARY, 32'h5A5A_0002, 1'b0);
        put_record(INNERBOUNDARY, 32'h0000_0000, 1'b0);
        wait_idle();

        while (gen_total < 900) begin
            set_layout(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)));
            nrec = $urandom_range(3, 10);
            cfg_write(REG_RECORD_COUNT, nrec);
            for (int r = 0; r < nrec; r++) put_random_record();
            wait_idle();
        end

        ending = $urandom_range(0, 3);
        if (ending == 1) begin
            cfg_write(REG_RECORD_COUNT, 3);
            put_record(LINEARRING, $urandom, 1'b1);
        end else if (ending == 2) begin
            cfg_write(REG_FORMAT_VERSION, 32'($urandom_range(0, 1) ? 2'd0 : 2'd3));
        end else if (ending == 3) begin
            cfg_write(REG_RECORD_COUNT, 0);
        end
        for (int t = 0; t < 6; t++) put8(8'($urandom));
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (n_err == 0)
            $display("delta_coded_polygon_stream_parser_core_tb: done, clean");
        else
            $display("delta_coded_polygon_stream_parser_core_tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("delta_coded_polygon_stream_parser_core_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hdl/dcpsp_pkg.sv
hdl/dcpsp_parser.sv
hdl/dcpsp_skid.sv
hdl/delta_coded_polygon_stream_parser_core.sv
hdl/dcpsp_checker.sv
tb/sv/delta_coded_polygon_stream_parser_core_tb.sv
